FILE: src/ptsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_pkg
// Shared types, constants and helpers for the pan/tilt scan transform.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  localparam int DefMaxBeams = 1024;

  // Quarter-wave odd polynomial coefficients, Q30: (pi/2)^k / k!
  localparam logic [30:0] CoefC1 = 31'd1686629713;
  localparam logic [30:0] CoefC3 = 31'd693598668;
  localparam logic [30:0] CoefC5 = 31'd85569306;
  localparam logic [30:0] CoefC7 = 31'd5026995;
  localparam logic [30:0] CoefC9 = 31'd172272;

  localparam logic [15:0] QuarterTurn = 16'd16384;

  localparam logic [15:0] RstBeamStep = 16'd0;
  localparam logic [11:0] RstFwdOff   = 12'd105;
  localparam logic [11:0] RstSideOff  = 12'd37;
  localparam logic [11:0] RstArmOff   = 12'd106;
  localparam logic [11:0] RstHgtOff   = 12'd121;

  localparam int NumStages = 11;

  typedef enum logic [2:0] {
    RegBeamStep = 3'd0,
    RegFwdOff   = 3'd1,
    RegSideOff  = 3'd2,
    RegArmOff   = 3'd3,
    RegHgtOff   = 3'd4
  } cfg_reg_e;

  // Working set handed from one Horner cell to the next
  typedef struct packed {
    logic [14:0] f;
    logic [30:0] u2;
    logic [30:0] t;
    logic        neg;
  } sin_bus_t;

  // floor((v + 2^(sh-1)) / 2^sh), saturated to 18 bits signed
  function automatic logic signed [17:0] round_sat(input logic signed [51:0] v,
                                                   input int unsigned sh);
    logic signed [51:0] w;
    logic signed [51:0] r;
    logic signed [17:0] res;
    w = v + (52'sd1 <<< (sh - 1));
    r = w >>> sh;
    if (r > 52'sd131071) begin
      res = 18'sd131071;
    end else if (r < -52'sd131072) begin
      res = -18'sd131072;
    end else begin
      res = r[17:0];
    end
    return res;
  endfunction

endpackage

FILE: src/ptsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_if
// Valid/ready channels for laser beams in and map-frame points out.
// ----------------------------------------------------------------------------
interface ptsc_beam_if;
  logic               valid;
  logic               ready;
  logic [15:0]        range_mm;
  logic [9:0]         beam_index;
  logic signed [15:0] pan_angle;
  logic signed [15:0] tilt_angle;

  modport source (output valid, range_mm, beam_index, pan_angle, tilt_angle, input ready);
  modport sink   (input valid, range_mm, beam_index, pan_angle, tilt_angle, output ready);
endinterface

interface ptsc_point_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] point_x_mm;
  logic signed [17:0] point_y_mm;
  logic signed [17:0] point_z_mm;

  modport source (output valid, point_x_mm, point_y_mm, point_z_mm, input ready);
  modport sink   (input valid, point_x_mm, point_y_mm, point_z_mm, output ready);
endinterface

FILE: src/pan_tilt_scan_to_cartesian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_scan_to_cartesian
// Laser beam (range, index, pan, tilt) to map-frame x/y/z point in mm.
// ----------------------------------------------------------------------------
// The block takes one beam transaction per clock while the output side keeps
// up, and returns one point per beam, in order. Throughput is set by the
// seven parallel sine lanes, each a row of Horner cells that hands its
// partial polynomial on each cycle that it is not stalled; stalls on the
// output side hold only the stages that are full, so bubbles close up and
// input keeps flowing until the whole pipe is occupied. Registers sit on an
// APB-style port at byte address 4*index and must be written while idle.
module pan_tilt_scan_to_cartesian
  import ptsc_pkg::*;
#(
  parameter int MAX_BEAMS = DefMaxBeams
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptsc_beam_if.sink   beam_i,
  ptsc_point_if.source point_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // -------------------------------------------------------------- registers
  logic [15:0] step_q;
  logic [11:0] fwd_q, side_q, arm_q, hgt_q;
  cfg_reg_e    reg_sel;

  assign reg_sel = cfg_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= RstBeamStep;
      fwd_q  <= RstFwdOff;
      side_q <= RstSideOff;
      arm_q  <= RstArmOff;
      hgt_q  <= RstHgtOff;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegBeamStep: step_q <= pwdata[15:0];
        RegFwdOff:   fwd_q  <= pwdata[11:0];
        RegSideOff:  side_q <= pwdata[11:0];
        RegArmOff:   arm_q  <= pwdata[11:0];
        RegHgtOff:   hgt_q  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegBeamStep: prdata = {16'd0, step_q};
      RegFwdOff:   prdata = {20'd0, fwd_q};
      RegSideOff:  prdata = {20'd0, side_q};
      RegArmOff:   prdata = {20'd0, arm_q};
      RegHgtOff:   prdata = {20'd0, hgt_q};
      default:     prdata = 32'd0;
    endcase
  end

  // ----------------------------------------------------------- flow control
  // A stage advances when it is empty or the stage after it advances.
  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   en;

  always_comb begin
    en[NumStages] = point_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= beam_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign beam_i.ready  = en[0];
  assign point_o.valid = v_q[NumStages-1];

  // ----------------------------------------------- stage 0: angles, clamping
  logic [9:0]  idx_c;
  logic [25:0] beam_prod;
  logic [15:0] beam_q, sum_q, pan_q, tilt_q, r_q;

  always_comb begin
    idx_c     = (32'(beam_i.beam_index) >= MAX_BEAMS) ? 10'(MAX_BEAMS - 1)
                                                      : beam_i.beam_index;
    beam_prod = idx_c * step_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      beam_q <= beam_prod[15:0];
      sum_q  <= beam_i.pan_angle + beam_i.tilt_angle;
      pan_q  <= beam_i.pan_angle;
      tilt_q <= beam_i.tilt_angle;
      r_q    <= beam_i.range_mm;
    end
  end

  // ------------------------------------------ stages 1..6: seven sine lanes
  logic signed [15:0] cb, sb, cs, ss, cp, sp, st;
  logic [15:0] r_pipe [6];

  ptsc_sine_lane u_cb (.clk_i, .en_i(en[6:1]), .angle_i(beam_q + QuarterTurn), .sine_o(cb));
  ptsc_sine_lane u_sb (.clk_i, .en_i(en[6:1]), .angle_i(beam_q),               .sine_o(sb));
  ptsc_sine_lane u_cs (.clk_i, .en_i(en[6:1]), .angle_i(sum_q + QuarterTurn),  .sine_o(cs));
  ptsc_sine_lane u_ss (.clk_i, .en_i(en[6:1]), .angle_i(sum_q),                .sine_o(ss));
  ptsc_sine_lane u_cp (.clk_i, .en_i(en[6:1]), .angle_i(pan_q + QuarterTurn),  .sine_o(cp));
  ptsc_sine_lane u_sp (.clk_i, .en_i(en[6:1]), .angle_i(pan_q),                .sine_o(sp));
  ptsc_sine_lane u_st (.clk_i, .en_i(en[6:1]), .angle_i(tilt_q),               .sine_o(st));

  // Carry the range alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      r_pipe[0] <= r_q;
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k+1]) begin
        r_pipe[k] <= r_pipe[k-1];
      end
    end
  end

  // -------------------------------------------- stage 7: first products
  logic signed [16:0] r_s;
  logic signed [32:0] prc_q;
  logic signed [15:0] cs7_q, ss7_q, st7_q;
  logic signed [27:0] acp_q, asp_q;
  logic signed [28:0] sdx_q, sdy_q;
  logic signed [33:0] zs7_q;

  assign r_s = $signed({1'b0, r_pipe[5]});

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      prc_q <= r_s * cb;
      cs7_q <= cs;
      ss7_q <= ss;
      st7_q <= st;
      acp_q <= $signed(arm_q) * cp;
      asp_q <= $signed(arm_q) * sp;
      sdx_q <= 29'($signed(side_q) * ss) + 29'($signed(fwd_q) * cs);
      sdy_q <= 29'($signed(fwd_q) * ss) - 29'($signed(side_q) * cs);
      zs7_q <= 34'(r_s * sb) + (34'($signed(hgt_q)) <<< 15);
    end
  end

  // ------------------------------------------- stage 8: second products
  logic signed [48:0] xa_q, ya_q;
  logic signed [43:0] xb_q, yb_q;
  logic signed [28:0] sdx8_q, sdy8_q;
  logic signed [33:0] zs8_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      xa_q   <= prc_q * cs7_q;
      ya_q   <= prc_q * ss7_q;
      xb_q   <= acp_q * st7_q;
      yb_q   <= asp_q * st7_q;
      sdx8_q <= sdx_q;
      sdy8_q <= sdy_q;
      zs8_q  <= zs7_q;
    end
  end

  // ------------------------------------------------- stage 9: Q30 sums
  logic signed [51:0] xs_q, ys_q;
  logic signed [33:0] zs9_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      xs_q  <= 52'(xa_q) + (52'(sdx8_q) <<< 15) - 52'(xb_q);
      ys_q  <= 52'(ya_q) + (52'(sdy8_q) <<< 15) - 52'(yb_q);
      zs9_q <= zs8_q;
    end
  end

  // ------------------------------------- stage 10: round, saturate, hold
  logic signed [17:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      px_q <= round_sat(xs_q, 30);
      py_q <= round_sat(ys_q, 30);
      pz_q <= round_sat(52'(zs9_q), 15);
    end
  end

  assign point_o.point_x_mm = px_q;
  assign point_o.point_y_mm = py_q;
  assign point_o.point_z_mm = pz_q;

endmodule

FILE: src/ptsc_horner_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_horner_cell
// One Horner step of the quarter-wave sine: t = C - (u2*t >> 30).
// ----------------------------------------------------------------------------
module ptsc_horner_cell #(
  parameter logic [30:0] COEF = 31'd0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  ptsc_pkg::sin_bus_t  bus_i,
  output ptsc_pkg::sin_bus_t  bus_o
);
  import ptsc_pkg::*;

  logic [61:0] prod;
  sin_bus_t    bus_d, bus_q;

  always_comb begin
    prod    = bus_i.u2 * bus_i.t;
    bus_d   = bus_i;
    bus_d.t = 31'(COEF - prod[61:30]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign bus_o = bus_q;

endmodule

FILE: src/ptsc_sine_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_sine_lane
// Q1.15 sine of a binary angle through a chain of Horner cells.
// ----------------------------------------------------------------------------
module ptsc_sine_lane (
  input  logic               clk_i,
  input  logic [5:0]         en_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sine_o
);
  import ptsc_pkg::*;

  localparam logic [30:0] Coefs [4] = '{CoefC7, CoefC5, CoefC3, CoefC1};

  logic [14:0] f_raw;
  logic [14:0] f_fold;
  logic [29:0] ff;
  sin_bus_t    prep_d, prep_q;
  sin_bus_t    chain [5];
  logic [45:0] fin_prod;
  logic [31:0] s_q30;
  logic [17:0] s_rnd;
  logic [15:0] s_mag;
  logic signed [15:0] sine_d, sine_q;

  // Fold the angle onto the first quadrant
  always_comb begin
    f_raw       = {1'b0, angle_i[13:0]};
    f_fold      = angle_i[14] ? (15'd16384 - f_raw) : f_raw;
    ff          = f_fold * f_fold;
    prep_d.f    = f_fold;
    prep_d.u2   = {ff[28:0], 2'b00};
    prep_d.t    = CoefC9;
    prep_d.neg  = angle_i[15];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prep_q <= prep_d;
    end
  end

  assign chain[0] = prep_q;

  for (genvar k = 0; k < 4; k++) begin : g_cell
    ptsc_horner_cell #(.COEF(Coefs[k])) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i[k+1]),
      .bus_i (chain[k]),
      .bus_o (chain[k+1])
    );
  end

  // Final multiply by u, round to Q1.15, clamp and apply sign
  always_comb begin
    fin_prod = chain[4].f * chain[4].t;
    s_q30    = fin_prod[45:14];
    s_rnd    = 18'((s_q30 + 32'd16384) >> 15);
    s_mag    = (s_rnd > 18'd32767) ? 16'd32767 : s_rnd[15:0];
    sine_d   = chain[4].neg ? -$signed(s_mag) : $signed(s_mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

FILE: src/ptsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsc_checker
// Port-level checks on the scan transform, bound to the top level.
// ----------------------------------------------------------------------------
module ptsc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] out_x,
  input logic signed [17:0] out_y,
  input logic signed [17:0] out_z
);
  import ptsc_pkg::*;

  logic [3:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                && $stable(out_z))
    else $error("stalled result changed");

  // Empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");

  // Every result has an accepted beam behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> count_q != 4'd0)
    else $error("result without accepted beam");

  // Never more beams in flight than stages
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 4'(NumStages))
    else $error("too many beams in flight");

endmodule

bind pan_tilt_scan_to_cartesian ptsc_checker u_ptsc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (beam_i.valid),
  .in_ready  (beam_i.ready),
  .out_valid (point_o.valid),
  .out_ready (point_o.ready),
  .out_x     (point_o.point_x_mm),
  .out_y     (point_o.point_y_mm),
  .out_z     (point_o.point_z_mm)
);

FILE: dv/tb_pan_tilt_scan_to_cartesian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pan_tilt_scan_to_cartesian
// Self-checking bench for the pan/tilt scan to map-frame point transform.
// ----------------------------------------------------------------------------
// Drive a directed table of beams, then random beams over several register
// settings and idling phases; predict every point in the bench and compare
// each returned point, field by field, with the oldest prediction.
module tb_pan_tilt_scan_to_cartesian;
  import ptsc_pkg::*;

  localparam int MaxBeams  = 1024;
  localparam int Latency   = NumStages + 4;
  localparam int CycleCap  = 400000;
  localparam int NumPhases = 5;

  // Polynomial coefficients for the quarter-wave sine, Q30
  localparam longint unsigned KC1 = 64'd1686629713;
  localparam longint unsigned KC3 = 64'd693598668;
  localparam longint unsigned KC5 = 64'd85569306;
  localparam longint unsigned KC7 = 64'd5026995;
  localparam longint unsigned KC9 = 64'd172272;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } point_t;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic [9:0]         beam_index;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
    logic               has_known;
    point_t             known;
  } beam_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ptsc_beam_if  beam_bus();
  ptsc_point_if point_bus();

  pan_tilt_scan_to_cartesian #(.MAX_BEAMS(MaxBeams)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beam_i  (beam_bus.sink),
    .point_o (point_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Bench copy of the register file
  logic [15:0] step_q;
  logic [11:0] fwd_q, side_q, arm_q, hgt_q;

  point_t      pending_points[$];
  int unsigned errors = 0;
  int unsigned points_seen = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // Quarter-wave sine, f in 0..16384, Q1.15 result
  function automatic longint quarter_wave(input longint unsigned f);
    longint unsigned u, u2, t, s;
    u  = f << 16;
    u2 = (u * u) >> 30;
    t  = KC9;
    t  = KC7 - ((u2 * t) >> 30);
    t  = KC5 - ((u2 * t) >> 30);
    t  = KC3 - ((u2 * t) >> 30);
    t  = KC1 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    s  = (s + 16384) >> 15;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint sine_of(input logic [15:0] a);
    longint unsigned f;
    longint s;
    f = a[13:0];
    if (a[14]) f = 16384 - f;
    s = quarter_wave(f);
    return a[15] ? -s : s;
  endfunction

  function automatic longint cosine_of(input logic [15:0] a);
    return sine_of(a + QuarterTurn);
  endfunction

  // Round half up by 2^sh, then clamp to 18 bits signed
  function automatic logic signed [17:0] round_clamp(input longint v, input int sh);
    longint r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  function automatic point_t map_point(input logic [15:0] rng, input logic [9:0] idx,
                                       input logic [15:0] pan, input logic [15:0] tilt);
    logic [15:0] beam_ang, sum_ang;
    longint r, cb, sb, cs, ss, cp, sp, st, f, sd, am, hg, xs, ys, zs;
    point_t p;
    r  = rng;
    // index width equals the beam limit, so no clamp is reachable here
    beam_ang = 16'(32'(idx) * 32'(step_q));
    sum_ang  = pan + tilt;
    cb = cosine_of(beam_ang);
    sb = sine_of(beam_ang);
    cs = cosine_of(sum_ang);
    ss = sine_of(sum_ang);
    cp = cosine_of(pan);
    sp = sine_of(pan);
    st = sine_of(tilt);
    f  = longint'($signed(fwd_q));
    sd = longint'($signed(side_q));
    am = longint'($signed(arm_q));
    hg = longint'($signed(hgt_q));
    xs = r * cb * cs + (sd * ss + f * cs) * 32768 - am * cp * st;
    ys = r * cb * ss + (f * ss - sd * cs) * 32768 - am * sp * st;
    zs = r * sb + hg * 32768;
    p.x = round_clamp(xs, 30);
    p.y = round_clamp(ys, 30);
    p.z = round_clamp(zs, 15);
    return p;
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall, compare each accepted point with the oldest prediction
  initial point_bus.ready = 1'b0;
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && point_bus.valid && point_bus.ready) begin
      points_seen <= points_seen + 1;
      if (pending_points.size() == 0) begin
        $error("point with no prediction waiting: x=%0d y=%0d z=%0d",
               point_bus.point_x_mm, point_bus.point_y_mm, point_bus.point_z_mm);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (point_bus.point_x_mm !== want.x) begin
          $error("point_x_mm: expected %0d, got %0d", want.x, point_bus.point_x_mm);
          errors++;
        end
        if (point_bus.point_y_mm !== want.y) begin
          $error("point_y_mm: expected %0d, got %0d", want.y, point_bus.point_y_mm);
          errors++;
        end
        if (point_bus.point_z_mm !== want.z) begin
          $error("point_z_mm: expected %0d, got %0d", want.z, point_bus.point_z_mm);
          errors++;
        end
      end
    end
    point_bus.ready <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Register write: setup phase, access phase until pready, then idle
  task automatic write_reg(input cfg_reg_e sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(sel) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      RegBeamStep: step_q = value[15:0];
      RegFwdOff:   fwd_q  = value[11:0];
      RegSideOff:  side_q = value[11:0];
      RegArmOff:   arm_q  = value[11:0];
      RegHgtOff:   hgt_q  = value[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] st, input logic [11:0] f, input logic [11:0] s,
                           input logic [11:0] a, input logic [11:0] h);
    write_reg(RegBeamStep, {16'h0, st});
    write_reg(RegFwdOff, {20'h0, f});
    write_reg(RegSideOff, {20'h0, s});
    write_reg(RegArmOff, {20'h0, a});
    write_reg(RegHgtOff, {20'h0, h});
  endtask

  // Send one beam; hold valid until accepted; queue the prediction on acceptance
  task automatic send_beam(input beam_row_t row);
    point_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      beam_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    beam_bus.valid      <= 1'b1;
    beam_bus.range_mm   <= row.range_mm;
    beam_bus.beam_index <= row.beam_index;
    beam_bus.pan_angle  <= row.pan;
    beam_bus.tilt_angle <= row.tilt;
    do @(posedge clk_i); while (!beam_bus.ready);
    want = row.has_known ? row.known :
           map_point(row.range_mm, row.beam_index, row.pan, row.tilt);
    pending_points.push_back(want);
  endtask

  // Drain: wait for all predictions, then let the pipe settle
  task automatic drain();
    beam_bus.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Random beam: mostly plausible scans, some full-range noise
  function automatic beam_row_t random_beam();
    beam_row_t b;
    b = '0;
    b.range_mm   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000));
    b.beam_index = ($urandom_range(7) == 0) ? 10'(MaxBeams - 1) : 10'($urandom);
    b.pan        = 16'($urandom);
    b.tilt       = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192) - 4096);
    return b;
  endfunction

  beam_row_t directed[$];

  initial begin
    beam_bus.valid      = 1'b0;
    beam_bus.range_mm   = '0;
    beam_bus.beam_index = '0;
    beam_bus.pan_angle  = '0;
    beam_bus.tilt_angle = '0;
    step_q = RstBeamStep;
    fwd_q  = RstFwdOff;
    side_q = RstSideOff;
    arm_q  = RstArmOff;
    hgt_q  = RstHgtOff;

    // Directed table. Known points: zero range at zero angles with reset
    // offsets gives (105, -37, 121); full range straight ahead gives the
    // largest planar x.
    //            range     index  pan        tilt       known?  x        y       z
    directed = '{
      '{16'd0,     10'd0,    16'sd0,     16'sd0,     1'b1, '{18'sd105, -18'sd37, 18'sd121}},
      '{16'hFFFF,  10'd0,    16'sd0,     16'sd0,     1'b0, '0},
      '{16'd0,     10'd1023, 16'sd0,     16'sd0,     1'b1, '{18'sd105, -18'sd37, 18'sd121}},
      '{16'd1000,  10'd5,    16'sd16384, 16'sd0,     1'b0, '0},
      '{16'd1000,  10'd5,    -16'sd32768, 16'sd0,    1'b0, '0},
      '{16'd1000,  10'd5,    16'sd32767, 16'sd32767, 1'b0, '0},
      '{16'd1000,  10'd5,    -16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'd500,   10'd7,    16'sd8192,  16'sd16384, 1'b0, '0},
      '{16'd500,   10'd7,    16'sd0,     -16'sd16384, 1'b0, '0},
      '{16'hFFFF,  10'd1023, 16'sd30000, 16'sd10000, 1'b0, '0},
      '{16'h5555,  10'h2AA,  16'sh5555,  16'shAAAA,  1'b0, '0},
      '{16'hAAAA,  10'h155,  16'shAAAA,  16'sh5555,  1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset settings, then again with extreme registers
    foreach (directed[i]) send_beam(directed[i]);
    drain();
    write_all(16'hFFFF, 12'h7FF, 12'h800, 12'h7FF, 12'h800);
    foreach (directed[i]) begin
      directed[i].has_known = 1'b0;
      send_beam(directed[i]);
    end
    drain();

    // Random phases across settings and idling patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        3: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
        default: begin sender_idle_pct = $urandom_range(30); receiver_stall_pct = 0; end
      endcase
      case (ph)
        0: write_all(16'd64, 12'd105, 12'd37, 12'd106, 12'd121);
        1: write_all(16'd0, 12'h800, 12'h7FF, 12'h800, 12'h7FF);
        default: write_all(16'($urandom), 12'($urandom), 12'($urandom),
                           12'($urandom), 12'($urandom));
      endcase
      repeat (120) send_beam(random_beam());
      drain();
    end

    $display("Covered %0d points: directed extremes at reset and extreme settings,",
             points_seen);
    $display("then random beams over %0d register settings and idling phases.", NumPhases);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
